[sv/bbps_pkg.sv]
package bbps_pkg;

  // Tune pattern width and the counters that walk it
  localparam int TUNE_W     = 32;
  localparam int TUNE_CNT_W = $clog2(TUNE_W + 1);
  localparam int TUNE_IDX_W = $clog2(TUNE_W);
  localparam int TUNE_LVL   = $clog2(TUNE_W);

  localparam int COUNT_W    = 17;
  localparam int TICK_W     = 8;
  localparam int PWM_W      = 10;
  localparam int DUTY_W     = 9;

  localparam logic [PWM_W-1:0] PWM_FULL_RST = 10'd1023;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_LED   = 2'd2,
    REQ_RSVD  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    MODE_COUNTED  = 2'd0,
    MODE_INFINITE = 2'd1,
    MODE_FOLLOW   = 2'd2,
    MODE_RSVD     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_INVERT    = 2'd0,
    CFG_FREQ      = 2'd1,
    CFG_PWM_FULL  = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [15:0]       beep_count;
    logic [7:0]        on_time;
    logic [7:0]        off_time;
    logic [TUNE_W-1:0] tune_bits;
    logic [1:0]        repeat_mode;
    logic              led_on;
  } in_t;

  typedef struct packed {
    logic              buzzer_level;
    logic              write_strobe;
    logic [DUTY_W-1:0] pwm_duty;
    logic              busy_res;
  } out_t;

  // Number of bits from the highest set bit down to bit 0; 0 for an empty tune.
  // Binary search over halves, one level per step.
  function automatic logic [TUNE_CNT_W-1:0] tune_len_f(logic [TUNE_W-1:0] v);
    logic [TUNE_W-1:0]     w;
    logic [TUNE_CNT_W-1:0] pos;
    w   = v;
    pos = '0;
    for (int k = TUNE_LVL - 1; k >= 0; k--) begin
      if ((w >> (1 << k)) != '0) begin
        pos = pos + TUNE_CNT_W'(1 << k);
        w   = w >> (1 << k);
      end
    end
    if (v == '0) begin
      return '0;
    end else begin
      return pos + TUNE_CNT_W'(1);
    end
  endfunction

endpackage

[sv/buzzer_beep_pattern_sequencer_unit.sv]
// Buzzer beep and tune sequencer.
// Input channel (in_valid/in_ready/in_data) takes three kinds of beat: a start
// command, a 100 ms tick and an LED state event. Every accepted beat yields
// exactly one result beat on the output channel (out_valid/out_ready/out_data)
// carrying the buzzer level, a write strobe, the PWM duty and the busy flag.
// The result is registered at the edge that accepts the input. Throughput is
// one beat per cycle while in_ready stays high; the whole step, including the
// leading-zero count of the tune, sits between the state registers and the
// output register.
// A one-entry skid register behind the output register lets the block take a
// further beat while the receiver stalls; in_ready drops only when both are
// full, and results leave strictly in order.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready and
// should be written only while the block is idle; unknown indexes are ignored.
// Synchronous active-low reset clears all sequencer state, empties the output
// stages and sets the PWM full scale to its maximum, polarity normal, level mode.
module buzzer_beep_pattern_sequencer_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bbps_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bbps_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [bbps_pkg::PWM_W-1:0]          cfg_data
);

  // Configuration registers
  logic                         invert_r;
  logic                         freq_r;
  logic [bbps_pkg::PWM_W-1:0]   pwm_full_r;

  // Sequencer state
  logic                           en_r,     en_nxt;
  logic [1:0]                     mode_r,   mode_nxt;
  logic [bbps_pkg::COUNT_W-1:0]   hcl_r,    hcl_nxt;
  logic [bbps_pkg::TICK_W-1:0]    ticks_r,  ticks_nxt;
  logic [bbps_pkg::TICK_W-1:0]    on_r,     on_nxt;
  logic [bbps_pkg::TICK_W-1:0]    off_r,    off_nxt;
  logic [bbps_pkg::TUNE_W-1:0]    tune_r,   tune_nxt;
  logic [bbps_pkg::TUNE_CNT_W-1:0] tleft_r, tleft_nxt;
  logic [bbps_pkg::TUNE_CNT_W-1:0] tlen_r,  tlen_nxt;
  logic                           cur_r,    cur_nxt;
  logic                           last_r,   last_nxt;

  // Output stages
  logic                 out_valid_r;
  bbps_pkg::out_t       out_data_r;
  logic                 skid_valid_r;
  bbps_pkg::out_t       skid_data_r;

  logic                 acc;
  logic                 pop;
  bbps_pkg::out_t       res;
  logic                 do_drive;
  logic                 drv_lvl;
  logic                 lvl;
  logic [bbps_pkg::TICK_W-1:0]     tdec;
  logic [bbps_pkg::COUNT_W-1:0]    hcl_dec;
  logic [bbps_pkg::TUNE_IDX_W-1:0] tidx;
  logic [bbps_pkg::TUNE_CNT_W-1:0] tidx_full;

  assign in_ready  = !skid_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign acc       = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;

  assign tidx_full = tleft_r - bbps_pkg::TUNE_CNT_W'(1);
  assign tidx      = tidx_full[bbps_pkg::TUNE_IDX_W-1:0];

  // One sequencer step per beat
  always_comb begin
    en_nxt    = en_r;
    mode_nxt  = mode_r;
    hcl_nxt   = hcl_r;
    ticks_nxt = ticks_r;
    on_nxt    = on_r;
    off_nxt   = off_r;
    tune_nxt  = tune_r;
    tleft_nxt = tleft_r;
    tlen_nxt  = tlen_r;
    cur_nxt   = cur_r;
    last_nxt  = last_r;
    do_drive  = 1'b0;
    drv_lvl   = 1'b0;
    tdec      = ticks_r - bbps_pkg::TICK_W'(1);
    hcl_dec   = hcl_r - ((tune_r != '0) ? bbps_pkg::COUNT_W'(2) : bbps_pkg::COUNT_W'(1));
    res       = '0;

    case (in_data.req_type)
      bbps_pkg::REQ_START: begin
        on_nxt    = in_data.on_time;
        off_nxt   = in_data.off_time;
        ticks_nxt = bbps_pkg::TICK_W'(1);
        mode_nxt  = in_data.repeat_mode;
        tune_nxt  = in_data.tune_bits;
        tlen_nxt  = bbps_pkg::tune_len_f(in_data.tune_bits);
        tleft_nxt = bbps_pkg::tune_len_f(in_data.tune_bits);
        hcl_nxt   = {in_data.beep_count, 1'b0};
        en_nxt    = (in_data.beep_count != '0);
        // count of zero stops the buzzer straight away
        if (in_data.beep_count == '0) begin
          do_drive = 1'b1;
        end
      end
      bbps_pkg::REQ_TICK: begin
        if (en_r && (mode_r != bbps_pkg::MODE_FOLLOW)) begin
          if (hcl_r == '0) begin
            en_nxt = 1'b0;
          end else begin
            do_drive = 1'b1;
            if (ticks_r != '0) begin
              ticks_nxt = tdec;
              if (tdec == '0) begin
                if (tleft_r != '0) begin
                  // next tune bit, most significant first
                  tleft_nxt = tidx_full;
                  cur_nxt   = tune_r[tidx];
                end else begin
                  // end of a pass: reload tune and step the count
                  tleft_nxt = tlen_r;
                  cur_nxt   = hcl_dec[0];
                  if (mode_r != bbps_pkg::MODE_COUNTED) begin
                    hcl_nxt = hcl_dec | bbps_pkg::COUNT_W'(2);
                  end else begin
                    hcl_nxt = hcl_dec;
                  end
                end
                ticks_nxt = cur_nxt ? on_r : off_r;
              end
            end
            drv_lvl = cur_nxt;
          end
        end
      end
      bbps_pkg::REQ_LED: begin
        if (en_r && (mode_r == bbps_pkg::MODE_FOLLOW)) begin
          cur_nxt  = in_data.led_on;
          do_drive = 1'b1;
          drv_lvl  = in_data.led_on;
        end
      end
      default: begin
      end
    endcase

    // Output drive: polarity, then level or PWM write
    lvl = drv_lvl ^ invert_r;
    if (do_drive) begin
      res.buzzer_level = lvl;
      if (freq_r) begin
        if (lvl != last_r) begin
          res.write_strobe = 1'b1;
          res.pwm_duty     = lvl ? pwm_full_r[bbps_pkg::PWM_W-1:1] : '0;
          last_nxt         = lvl;
        end
      end else begin
        res.write_strobe = 1'b1;
      end
    end
    res.busy_res = en_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r   <= 1'b0;
      freq_r     <= 1'b0;
      pwm_full_r <= bbps_pkg::PWM_FULL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bbps_pkg::CFG_INVERT:   invert_r   <= cfg_data[0];
        bbps_pkg::CFG_FREQ:     freq_r     <= cfg_data[0];
        bbps_pkg::CFG_PWM_FULL: pwm_full_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer state update on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b0;
      mode_r  <= bbps_pkg::MODE_COUNTED;
      hcl_r   <= '0;
      ticks_r <= '0;
      on_r    <= '0;
      off_r   <= '0;
      tune_r  <= '0;
      tleft_r <= '0;
      tlen_r  <= '0;
      cur_r   <= 1'b0;
      last_r  <= 1'b0;
    end else if (acc) begin
      en_r    <= en_nxt;
      mode_r  <= mode_nxt;
      hcl_r   <= hcl_nxt;
      ticks_r <= ticks_nxt;
      on_r    <= on_nxt;
      off_r   <= off_nxt;
      tune_r  <= tune_nxt;
      tleft_r <= tleft_nxt;
      tlen_r  <= tlen_nxt;
      cur_r   <= cur_nxt;
      last_r  <= last_nxt;
    end
  end

  // Output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (acc) begin
      if (!out_valid_r || pop) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a beat while output register is empty");

  a_tune_pos: assert property (@(posedge clk) disable iff (!rst_n)
    tleft_r <= tlen_r)
    else $error("tune position beyond tune length");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !en_r |-> (hcl_r == '0))
    else $error("sequencer disabled with beats still pending");

  a_duty_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.pwm_duty != '0)) |->
      (out_data_r.write_strobe && out_data_r.buzzer_level))
    else $error("PWM duty without an on-level write");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ready) |=> (skid_valid_r && $stable(skid_data_r)))
    else $error("stalled skid beat lost or changed");
`endif

endmodule

[tb/sv/tb_buzzer_beep_pattern_sequencer_unit.sv]
module tb_buzzer_beep_pattern_sequencer_unit;

  localparam int PHASES     = 8;
  localparam int RAND_BEATS = 1525;
  localparam bbps_pkg::out_t QUIET = '0;

  // one row of the directed table; res is only used when pinned is set
  typedef struct {
    bbps_pkg::in_t  item;
    bit             pinned;
    bbps_pkg::out_t res;
  } row_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  bbps_pkg::in_t              in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  bbps_pkg::out_t             out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index = bbps_pkg::CFG_INVERT;
  logic [bbps_pkg::PWM_W-1:0] cfg_data = '0;

  // typed-in result travelling alongside the current input beat
  logic           in_pinned = 1'b0;
  bbps_pkg::out_t in_pin_res = '0;

  bit             no_idle = 1'b0;
  int             stall_left = 0;
  int             mism_count = 0;
  bbps_pkg::out_t buzz_due[$];
  row_t           dir_rows[$];

  // local copy of the registers
  logic                       m_invert = 1'b0;
  logic                       m_freq = 1'b0;
  logic [bbps_pkg::PWM_W-1:0] m_range = bbps_pkg::PWM_FULL_RST;

  // sequencer state as the block should hold it
  logic                         s_enabled = 1'b0;
  bbps_pkg::mode_t              s_mode = bbps_pkg::MODE_COUNTED;
  logic [bbps_pkg::COUNT_W-1:0] s_half = '0;
  logic [bbps_pkg::TICK_W-1:0]  s_ticks = '0;
  logic [bbps_pkg::TICK_W-1:0]  s_on_t = '0;
  logic [bbps_pkg::TICK_W-1:0]  s_off_t = '0;
  logic [bbps_pkg::TUNE_W-1:0]  s_shift = '0;
  logic [bbps_pkg::TUNE_W-1:0]  s_reload = '0;
  logic [5:0]                   s_bits_left = '0;
  logic [5:0]                   s_len = '0;
  logic                         s_on = 1'b0;
  logic                         s_last_lvl = 1'b0;

  buzzer_beep_pattern_sequencer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb_buzzer_beep_pattern_sequencer_unit: done, errors");
    $finish;
  end

  // Level handed to the driver: polarity, then the freq-mode change filter
  function automatic bbps_pkg::out_t buzz_drive(logic lvl);
    bbps_pkg::out_t r;
    logic v;
    r = '0;
    v = lvl ^ m_invert;
    r.buzzer_level = v;
    if (m_freq) begin
      if (v != s_last_lvl) begin
        r.write_strobe = 1'b1;
        r.pwm_duty     = v ? m_range[bbps_pkg::PWM_W-1:1] : '0;
        s_last_lvl     = v;
      end
    end else begin
      r.write_strobe = 1'b1;
    end
    return r;
  endfunction

  // Advance the sequencer by one input beat and give the result it causes
  function automatic bbps_pkg::out_t buzz_step(bbps_pkg::in_t it);
    bbps_pkg::out_t r;
    int len;
    logic [bbps_pkg::TUNE_W-1:0] rev;
    r = '0;
    case (bbps_pkg::req_t'(it.req_type))
      bbps_pkg::REQ_START: begin
        // tune length up to the top set bit, reversed so the MSB plays first
        len = 0;
        for (int k = 0; k < bbps_pkg::TUNE_W; k++) begin
          if (it.tune_bits[k]) len = k + 1;
        end
        rev = '0;
        for (int j = 0; j < len; j++) rev[len-1-j] = it.tune_bits[j];
        s_off_t     = it.off_time;
        s_on_t      = it.on_time;
        s_ticks     = 8'd1;
        s_mode      = bbps_pkg::mode_t'(it.repeat_mode);
        s_len       = 6'(len);
        s_bits_left = 6'(len);
        s_reload    = rev;
        s_shift     = rev;
        s_half      = {it.beep_count, 1'b0};
        s_enabled   = (s_half != '0);
        if (!s_enabled) r = buzz_drive(1'b0);
      end
      bbps_pkg::REQ_TICK: begin
        if (s_enabled && s_mode != bbps_pkg::MODE_FOLLOW) begin
          if (s_half == '0) begin
            s_enabled = 1'b0;
          end else begin
            if (s_ticks != '0) begin
              s_ticks = s_ticks - 8'd1;
              if (s_ticks == '0) begin
                if (s_bits_left != '0) begin
                  s_bits_left = s_bits_left - 6'd1;
                  s_on        = s_shift[0];
                  s_shift     = s_shift >> 1;
                end else begin
                  // end of a pass: reload tune, step the half-cycle count
                  s_bits_left = s_len;
                  s_shift     = s_reload;
                  s_half      = s_half - ((s_reload != '0) ? 17'd2 : 17'd1);
                  s_on        = s_half[0];
                  if (s_mode != bbps_pkg::MODE_COUNTED) s_half[1] = 1'b1;
                end
                s_ticks = s_on ? s_on_t : s_off_t;
              end
            end
            r = buzz_drive(s_on);
          end
        end
      end
      bbps_pkg::REQ_LED: begin
        if (s_enabled && s_mode == bbps_pkg::MODE_FOLLOW) begin
          s_on = it.led_on;
          r    = buzz_drive(s_on);
        end
      end
      default: ;
    endcase
    r.busy_res = s_enabled;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic bbps_pkg::in_t beat(bbps_pkg::req_t rq, int cnt, int on_t, int off_t,
                                         logic [bbps_pkg::TUNE_W-1:0] tune,
                                         bbps_pkg::mode_t md, logic led);
    bbps_pkg::in_t it;
    it.req_type    = rq;
    it.beep_count  = 16'(cnt);
    it.on_time     = 8'(on_t);
    it.off_time    = 8'(off_t);
    it.tune_bits   = tune;
    it.repeat_mode = md;
    it.led_on      = led;
    return it;
  endfunction

  // Append one row to the directed table
  task automatic add_row(bbps_pkg::in_t it, bit pinned, bbps_pkg::out_t res);
    row_t r;
    r.item   = it;
    r.pinned = pinned;
    r.res    = res;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // Mostly ticks and LED events with the odd start; short counts and
  // durations so that sequences run through to their end
  function automatic bbps_pkg::in_t rand_beat();
    bbps_pkg::in_t it;
    int r;
    it.beep_count  = 16'($urandom);
    it.on_time     = 8'($urandom);
    it.off_time    = 8'($urandom);
    it.tune_bits   = $urandom;
    it.repeat_mode = 2'($urandom);
    it.led_on      = 1'($urandom);
    r = $urandom_range(0, 99);
    if (r < 9) begin
      it.req_type = bbps_pkg::REQ_START;
      r = $urandom_range(0, 99);
      if (r < 10) it.beep_count = '0;
      else if (r < 80) it.beep_count = 16'($urandom_range(1, 4));
      if ($urandom_range(0, 99) < 85) it.on_time = 8'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 85) it.off_time = 8'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 40) it.tune_bits = '0;
      else if (r < 75) it.tune_bits = bbps_pkg::TUNE_W'($urandom_range(1, 63));
      else it.tune_bits = $urandom >> $urandom_range(0, 31);
    end else if (r < 74) begin
      it.req_type = bbps_pkg::REQ_TICK;
    end else if (r < 94) begin
      it.req_type = bbps_pkg::REQ_LED;
    end else begin
      it.req_type = bbps_pkg::REQ_RSVD;
    end
    return it;
  endfunction

  // Hold a beat until accepted; valid stays high unless a gap follows
  task automatic send_beat(bbps_pkg::in_t it, bit pinned, bbps_pkg::out_t pin_res);
    int g;
    in_valid   <= 1'b1;
    in_data    <= it;
    in_pinned  <= pinned;
    in_pin_res <= pin_res;
    do @(posedge clk); while (!in_ready);
    if (!no_idle) begin
      g = idle_len();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic put_cfg(bbps_pkg::cfg_idx_t idx, logic [bbps_pkg::PWM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Stop sending and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (buzz_due.size() != 0);
  endtask

  // Receiver stalls: mostly short, some long, none in the quiet phase
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 99) < 25) begin
      out_ready  <= 1'b0;
      stall_left <= idle_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Register writes, result checks and prediction on each accepted beat
  always @(posedge clk) begin : check_proc
    bbps_pkg::out_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (bbps_pkg::cfg_idx_t'(cfg_index))
          bbps_pkg::CFG_INVERT:   m_invert = cfg_data[0];
          bbps_pkg::CFG_FREQ:     m_freq   = cfg_data[0];
          bbps_pkg::CFG_PWM_FULL: m_range  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (buzz_due.size() == 0) begin
          mism_count++;
          if (mism_count <= 10)
            $display("unexpected result beat: lvl=%0d strobe=%0d duty=%0d busy=%0d",
                     out_data.buzzer_level, out_data.write_strobe,
                     out_data.pwm_duty, out_data.busy_res);
        end else begin
          want = buzz_due.pop_front();
          if (out_data.buzzer_level !== want.buzzer_level ||
              out_data.write_strobe !== want.write_strobe ||
              out_data.pwm_duty !== want.pwm_duty ||
              out_data.busy_res !== want.busy_res) begin
            mism_count++;
            if (mism_count <= 10)
              $display("mismatch: want lvl=%0d strobe=%0d duty=%0d busy=%0d, got %0d %0d %0d %0d",
                       want.buzzer_level, want.write_strobe, want.pwm_duty, want.busy_res,
                       out_data.buzzer_level, out_data.write_strobe,
                       out_data.pwm_duty, out_data.busy_res);
          end
        end
      end
      if (in_valid && in_ready) begin
        want = buzz_step(in_data);
        buzz_due.insert(buzz_due.size(), in_pinned ? in_pin_res : want);
      end
    end
  end

  initial begin : stim_proc
    bit                         ph_inv[PHASES];
    bit                         ph_freq[PHASES];
    int                         ph_pwm[PHASES];
    logic [bbps_pkg::PWM_W-1:0] pwm_full;

    ph_inv  = '{1, 0, 1, 0, 1, 0, 0, 1};
    ph_freq = '{0, 1, 1, 1, 1, 0, 1, 1};
    ph_pwm  = '{1023, 1023, 1, 0, 2, 512, -1, -1};

    // Directed beats under the reset register values
    add_row(beat(bbps_pkg::REQ_TICK, 0, 0, 0, 0, bbps_pkg::MODE_COUNTED, 0), 1'b1, QUIET);
    add_row(beat(bbps_pkg::REQ_LED, 0, 0, 0, 0, bbps_pkg::MODE_COUNTED, 1), 1'b1, QUIET);
    add_row(beat(bbps_pkg::REQ_RSVD, 65535, 255, 255, 32'hFFFF_FFFF, bbps_pkg::MODE_RSVD, 1),
            1'b1, QUIET);
    // count zero stops and drives low
    add_row(beat(bbps_pkg::REQ_START, 0, 255, 255, 32'hFFFF_FFFF, bbps_pkg::MODE_COUNTED, 0),
            1'b1, bbps_pkg::out_t'({1'b0, 1'b1, 9'd0, 1'b0}));
    add_row(beat(bbps_pkg::REQ_START, 65535, 255, 0, 0, bbps_pkg::MODE_COUNTED, 0),
            1'b1, bbps_pkg::out_t'({1'b0, 1'b0, 9'd0, 1'b1}));
    add_row(beat(bbps_pkg::REQ_TICK, 0, 0, 0, 0, bbps_pkg::MODE_COUNTED, 0), 1'b0, QUIET);
    // zero durations: countdown sticks, each tick re-drives
    add_row(beat(bbps_pkg::REQ_START, 1, 0, 0, 0, bbps_pkg::MODE_COUNTED, 0),
            1'b1, bbps_pkg::out_t'({1'b0, 1'b0, 9'd0, 1'b1}));
    add_row(beat(bbps_pkg::REQ_TICK, 0, 0, 0, 0, bbps_pkg::MODE_COUNTED, 0), 1'b0, QUIET);
    add_row(beat(bbps_pkg::REQ_TICK, 0, 0, 0, 0, bbps_pkg::MODE_COUNTED, 0), 1'b0, QUIET);
    // single beep to exhaustion
    add_row(beat(bbps_pkg::REQ_START, 1, 1, 1, 0, bbps_pkg::MODE_COUNTED, 0),
            1'b1, bbps_pkg::out_t'({1'b0, 1'b0, 9'd0, 1'b1}));
    add_row(beat(bbps_pkg::REQ_TICK, 0, 0, 0, 0, bbps_pkg::MODE_COUNTED, 0), 1'b0, QUIET);
    add_row(beat(bbps_pkg::REQ_TICK, 0, 0, 0, 0, bbps_pkg::MODE_COUNTED, 0), 1'b0, QUIET);
    add_row(beat(bbps_pkg::REQ_TICK, 0, 0, 0, 0, bbps_pkg::MODE_COUNTED, 0), 1'b1, QUIET);
    // full-width tune, infinite repeat
    add_row(beat(bbps_pkg::REQ_START, 1, 1, 1, 32'h8000_0001, bbps_pkg::MODE_INFINITE, 0),
            1'b1, bbps_pkg::out_t'({1'b0, 1'b0, 9'd0, 1'b1}));
    add_row(beat(bbps_pkg::REQ_TICK, 0, 0, 0, 0, bbps_pkg::MODE_COUNTED, 0), 1'b0, QUIET);
    add_row(beat(bbps_pkg::REQ_TICK, 0, 0, 0, 0, bbps_pkg::MODE_COUNTED, 0), 1'b0, QUIET);
    add_row(beat(bbps_pkg::REQ_TICK, 0, 0, 0, 0, bbps_pkg::MODE_COUNTED, 0), 1'b0, QUIET);
    add_row(beat(bbps_pkg::REQ_TICK, 0, 0, 0, 0, bbps_pkg::MODE_COUNTED, 0), 1'b0, QUIET);
    // reserved repeat mode acts as infinite
    add_row(beat(bbps_pkg::REQ_START, 2, 1, 2, 32'hFFFF_FFFF, bbps_pkg::MODE_RSVD, 0),
            1'b1, bbps_pkg::out_t'({1'b0, 1'b0, 9'd0, 1'b1}));
    add_row(beat(bbps_pkg::REQ_TICK, 0, 0, 0, 0, bbps_pkg::MODE_COUNTED, 0), 1'b0, QUIET);
    // follow mode: LED events drive, ticks do nothing
    add_row(beat(bbps_pkg::REQ_START, 3, 0, 0, 0, bbps_pkg::MODE_FOLLOW, 0),
            1'b1, bbps_pkg::out_t'({1'b0, 1'b0, 9'd0, 1'b1}));
    add_row(beat(bbps_pkg::REQ_LED, 0, 0, 0, 0, bbps_pkg::MODE_COUNTED, 1),
            1'b1, bbps_pkg::out_t'({1'b1, 1'b1, 9'd0, 1'b1}));
    add_row(beat(bbps_pkg::REQ_LED, 0, 0, 0, 0, bbps_pkg::MODE_COUNTED, 0),
            1'b1, bbps_pkg::out_t'({1'b0, 1'b1, 9'd0, 1'b1}));
    add_row(beat(bbps_pkg::REQ_TICK, 0, 0, 0, 0, bbps_pkg::MODE_COUNTED, 0),
            1'b1, bbps_pkg::out_t'({1'b0, 1'b0, 9'd0, 1'b1}));
    // one-bit tune
    add_row(beat(bbps_pkg::REQ_START, 1, 2, 1, 1, bbps_pkg::MODE_COUNTED, 0),
            1'b1, bbps_pkg::out_t'({1'b0, 1'b0, 9'd0, 1'b1}));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_beat(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].res);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      no_idle  = (ph == 2);
      pwm_full = (ph_pwm[ph] < 0) ? bbps_pkg::PWM_W'($urandom_range(0, 1023))
                                  : bbps_pkg::PWM_W'(ph_pwm[ph]);
      put_cfg(bbps_pkg::CFG_INVERT, bbps_pkg::PWM_W'(ph_inv[ph]));
      put_cfg(bbps_pkg::CFG_FREQ, bbps_pkg::PWM_W'(ph_freq[ph]));
      put_cfg(bbps_pkg::CFG_PWM_FULL, pwm_full);
      cfg_valid <= 1'b0;
      repeat (RAND_BEATS / PHASES) send_beat(rand_beat(), 1'b0, QUIET);
    end

    drain();
    repeat (8) @(posedge clk);
    if (mism_count == 0) begin
      $display("tb_buzzer_beep_pattern_sequencer_unit: done, clean");
    end else begin
      $display("tb_buzzer_beep_pattern_sequencer_unit: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/bbps_pkg.sv
sv/buzzer_beep_pattern_sequencer_unit.sv
tb/sv/tb_buzzer_beep_pattern_sequencer_unit.sv
